/* rtl/xor_keyed_rle_decoder_core_macros.svh */
// Assertion macros for the keyed run-length decoder.
`ifndef XOR_KEYED_RLE_DECODER_CORE_MACROS_SVH
`define XOR_KEYED_RLE_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define XKRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xkrd check failed");
// Next-cycle implication, disabled while in reset.
`define XKRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xkrd check failed");
`else
`define XKRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define XKRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/xkrd_pkg.sv */
`timescale 1ns / 1ps

package xkrd_pkg;

    localparam int SIZE_W     = 31;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIG_SIZE = 2'd2;

    typedef struct packed {
        logic [7:0]        xor_key;
        logic              compressed_mode;
        logic [SIZE_W-1:0] original_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_res;
        logic       last;
    } res_t;

endpackage

/* rtl/xor_keyed_rle_decoder_core.sv */
`timescale 1ns / 1ps
// An input byte is held in the input register, its result in the m_ side register.
// Throughput: one input byte per cycle unless m_ stalls; the running byte count
// and run state are updated in the same cycle that a byte is decoded.
// Reset (aresetn low, synchronous) empties both pipeline registers, restores the
// registers to key 0, compressed mode, size 0, and clears the decode state.
module xor_keyed_rle_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] repeat_res
    output logic        m_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    xkrd_pkg::cfg_t cfg;
    xkrd_pkg::res_t res;
    logic           res_valid;

    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           out_valid_reg;
    xkrd_pkg::res_t out_reg;
    logic           fire;

    // decode when a byte is held and the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    xkrd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    xkrd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .fire      (fire),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.repeat_res, out_reg.out_byte};
    assign m_tlast  = out_reg.last;

endmodule

/* rtl/xkrd_cfg_regs.sv */
`timescale 1ns / 1ps

module xkrd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xkrd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output xkrd_pkg::cfg_t                  cfg
);

    xkrd_pkg::cfg_t                   cfg_reg;
    logic [xkrd_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[xkrd_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.xor_key         <= 8'd0;
            cfg_reg.compressed_mode <= 1'b1;
            cfg_reg.original_size   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                xkrd_pkg::REG_XOR_KEY:   cfg_reg.xor_key <= pwdata[7:0];
                xkrd_pkg::REG_MODE:      cfg_reg.compressed_mode <= pwdata[0];
                xkrd_pkg::REG_ORIG_SIZE:
                    cfg_reg.original_size <= pwdata[xkrd_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            xkrd_pkg::REG_XOR_KEY:   prdata = {24'd0, cfg_reg.xor_key};
            xkrd_pkg::REG_MODE:      prdata = {31'd0, cfg_reg.compressed_mode};
            xkrd_pkg::REG_ORIG_SIZE: prdata = {1'b0, cfg_reg.original_size};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/xkrd_decode.sv */
`timescale 1ns / 1ps
`include "xor_keyed_rle_decoder_core_macros.svh"

module xkrd_decode (
    input  logic           aclk,
    input  logic           aresetn,
    input  xkrd_pkg::cfg_t cfg,
    input  logic           fire,
    input  logic [7:0]     in_byte,
    output logic           res_valid,
    output xkrd_pkg::res_t res
);

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_LITERAL = 2'd1,
        PH_COUNT   = 2'd2
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [7:0]                run_byte_reg, run_byte_next;
    logic [xkrd_pkg::SIZE_W-1:0] emitted_reg, emitted_next;

    logic [7:0]                  dec_byte;
    logic [xkrd_pkg::SIZE_W:0]   diff;
    logic [xkrd_pkg::SIZE_W-1:0] left;
    logic                        done;
    logic                        left_small;
    logic [7:0]                  value;
    logic [7:0]                  copies;
    logic [7:0]                  copies_clip;
    logic                        step;

    assign dec_byte = in_byte ^ cfg.xor_key;

    // remaining room; borrow or zero means the size is already reached
    assign diff       = {1'b0, cfg.original_size} - {1'b0, emitted_reg};
    assign left       = diff[xkrd_pkg::SIZE_W-1:0];
    assign done       = diff[xkrd_pkg::SIZE_W] || (left == '0);
    assign left_small = (left[xkrd_pkg::SIZE_W-1:8] == '0);
    assign step       = fire && !done;

    always_comb begin
        value         = dec_byte;
        copies        = 8'd1;
        phase_next    = phase_reg;
        run_byte_next = run_byte_reg;
        if (cfg.compressed_mode) begin
            case (phase_reg)
                PH_FIRST: begin
                    run_byte_next = dec_byte;
                    phase_next    = PH_LITERAL;
                end
                PH_COUNT: begin
                    value      = run_byte_reg;
                    copies     = dec_byte;
                    phase_next = PH_LITERAL;
                end
                default: begin
                    // literal; a repeat of the run byte means a count follows
                    phase_next    = (dec_byte == run_byte_reg) ? PH_COUNT : PH_LITERAL;
                    run_byte_next = dec_byte;
                end
            endcase
        end
    end

    always_comb begin
        if (left_small && (left[7:0] < copies)) begin
            copies_clip = left[7:0];
        end else begin
            copies_clip = copies;
        end
    end

    assign emitted_next   = emitted_reg + {{(xkrd_pkg::SIZE_W-8){1'b0}}, copies_clip};
    assign res_valid      = step && (copies_clip != 8'd0);
    assign res.out_byte   = value;
    assign res.repeat_res = copies_clip;
    assign res.last       = left_small && (copies_clip == left[7:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            run_byte_reg <= 8'd0;
            emitted_reg  <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            run_byte_reg <= run_byte_next;
            emitted_reg  <= emitted_next;
        end
    end

    `XKRD_ASSERT_NOW(a_nonzero_copies, aclk, aresetn, res_valid, res.repeat_res != 8'd0)
    `XKRD_ASSERT_NEXT(a_done_after_last, aclk, aresetn, res_valid && res.last, done)
    `XKRD_ASSERT_NEXT(a_plain_keeps_phase, aclk, aresetn, fire && !cfg.compressed_mode,
        $stable(phase_reg) && $stable(run_byte_reg))
    `XKRD_ASSERT_NEXT(a_done_holds_count, aclk, aresetn, fire && done, $stable(emitted_reg))

endmodule
